### rtl/core/hktf_pkg.sv
`default_nettype none

package hktf_pkg;

   // default table depth
   localparam int unsigned HELD_SLOTS_DEF = 8;

   // keycode translation
   localparam logic [7:0] KEY_OFFSET = 8'd8;
   localparam logic [6:0] PLAIN_MASK = 7'h7f;

   // raw event kinds
   typedef enum logic [1:0] {
      EV_DOWN   = 2'd0,
      EV_UP     = 2'd1,
      EV_ALL_UP = 2'd2,
      EV_SPARE  = 2'd3
   } event_kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EMIT,
      ST_UP_SCAN,
      ST_FL_PICK,
      ST_FL_EMIT
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic req_ready;
      logic capture;
      logic wr_slot;
      logic scan_init;
      logic rd_en;
      logic rd_flush;
      logic clear_slot;
      logic out_single;
      logic out_flush;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic           trk;
      event_kind_type kind;
      logic           any_valid;
      logic           up_hit;
      logic           up_end;
      logic           flush_last;
      logic           out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

### rtl/core/hktf_ifs.sv
`default_nettype none

// raw keyboard event channel
interface hktf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  key_value;
   logic [31:0] time_ms;

   modport source (output valid, event_kind, key_value, time_ms, input ready);
   modport sink   (input valid, event_kind, key_value, time_ms, output ready);
endinterface

// press / release result channel
interface hktf_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_release;
   logic [7:0]  keycode;
   logic [31:0] stamp_ms;
   logic        last;

   modport source (output valid, is_release, keycode, stamp_ms, last, input ready);
   modport sink   (input valid, is_release, keycode, stamp_ms, last, output ready);
endinterface

`default_nettype wire

### rtl/core/hktf_datapath.sv
`default_nettype none

module hktf_datapath #(
   parameter int unsigned HELD_SLOTS = hktf_pkg::HELD_SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic                 csr_wdata,
   input  wire logic [1:0]           req_event_kind,
   input  wire logic [7:0]           req_key_value,
   input  wire logic [31:0]          req_time_ms,
   input  wire hktf_pkg::ctl_cmd_type cmd,
   output hktf_pkg::dp_sts_type      sts,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_is_release,
   output logic [7:0]                rsp_keycode,
   output logic [31:0]               rsp_stamp_ms,
   output logic                      rsp_last
);
   import hktf_pkg::*;

   localparam int unsigned IDX_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(HELD_SLOTS + 1);

   logic                  mode_ff;
   logic                  trk_ff;
   event_kind_type        kind_ff;
   logic [7:0]            code_ff;
   logic [31:0]           stamp_ff;
   logic [HELD_SLOTS-1:0] valid_ff;
   logic [7:0]            slot_mem [HELD_SLOTS];
   logic [CNT_W-1:0]      scan_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [7:0]            rd_data_ff;
   logic                  rd_live_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_is_release_ff;
   logic [7:0]            rsp_keycode_ff;
   logic [31:0]           rsp_stamp_ms_ff;
   logic                  rsp_last_ff;

   logic [7:0]            code_in;
   logic [IDX_W-1:0]      first_empty;
   logic [IDX_W-1:0]      first_valid;
   logic                  has_empty;
   logic                  scan_ok;
   logic                  rd_go;
   logic [IDX_W-1:0]      rd_addr;
   logic [HELD_SLOTS-1:0] rd_mask;
   logic                  out_free;

   // keycode translation for the incoming beat
   always_comb begin
      if (mode_ff) begin
         code_in = req_key_value + KEY_OFFSET;
      end else begin
         code_in = {1'b0, req_key_value[6:0] & PLAIN_MASK} + KEY_OFFSET;
      end
   end

   // lowest empty and lowest held slot
   always_comb begin
      first_empty = '0;
      first_valid = '0;
      for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) first_empty = IDX_W'(i);
         if (valid_ff[i])  first_valid = IDX_W'(i);
      end
   end

   assign has_empty = ~&valid_ff;
   assign scan_ok   = (scan_ff < CNT_W'(HELD_SLOTS));
   assign rd_go     = cmd.rd_en && (cmd.rd_flush || scan_ok);
   assign rd_addr   = cmd.rd_flush ? first_valid : scan_ff[IDX_W-1:0];
   assign rd_mask   = HELD_SLOTS'(1) << rd_idx_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // captured event
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         trk_ff   <= mode_ff;
         kind_ff  <= event_kind_type'(req_event_kind);
         code_ff  <= code_in;
         stamp_ff <= req_time_ms;
      end
   end

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_slot && has_empty) begin
         valid_ff[first_empty] <= 1'b1;
      end else if (cmd.clear_slot) begin
         valid_ff <= valid_ff & ~rd_mask;
      end
   end

   // slot storage, write side
   always_ff @(posedge clock) begin
      if (cmd.wr_slot && has_empty) begin
         slot_mem[first_empty] <= code_ff;
      end
   end

   // slot storage, registered read
   always_ff @(posedge clock) begin
      if (rd_go) begin
         rd_data_ff <= slot_mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // scan counter and read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= rd_go && !cmd.rd_flush;
         if (cmd.scan_init) begin
            scan_ff <= '0;
         end else if (rd_go && !cmd.rd_flush) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_single || cmd.out_flush) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_single) begin
         rsp_is_release_ff <= (kind_ff == EV_UP);
         rsp_keycode_ff    <= code_ff;
         rsp_stamp_ms_ff   <= stamp_ff;
         rsp_last_ff       <= 1'b1;
      end else if (cmd.out_flush) begin
         rsp_is_release_ff <= 1'b1;
         rsp_keycode_ff    <= rd_data_ff;
         rsp_stamp_ms_ff   <= stamp_ff;
         rsp_last_ff       <= sts.flush_last;
      end
   end

   // status back to the controller
   always_comb begin
      sts.trk        = trk_ff;
      sts.kind       = kind_ff;
      sts.any_valid  = |valid_ff;
      sts.up_hit     = rd_live_ff && valid_ff[rd_idx_ff] && (rd_data_ff == code_ff);
      sts.up_end     = rd_live_ff && (rd_idx_ff == IDX_W'(HELD_SLOTS - 1));
      sts.flush_last = ((valid_ff & ~rd_mask) == '0);
      sts.out_free   = out_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_release = rsp_is_release_ff;
   assign rsp_keycode    = rsp_keycode_ff;
   assign rsp_stamp_ms   = rsp_stamp_ms_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/hktf_ctrl.sv
`default_nettype none

module hktf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire hktf_pkg::dp_sts_type sts,
   output hktf_pkg::ctl_cmd_type    cmd
);
   import hktf_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.trk && sts.kind == EV_UP) begin
               state_in = ST_UP_SCAN;
            end else if (sts.trk && sts.kind == EV_ALL_UP) begin
               state_in = sts.any_valid ? ST_FL_PICK : ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_UP_SCAN: begin
            if (sts.up_hit || sts.up_end) state_in = ST_EMIT;
         end
         ST_FL_PICK: begin
            state_in = ST_FL_EMIT;
         end
         ST_FL_EMIT: begin
            if (sts.out_free) state_in = sts.flush_last ? ST_IDLE : ST_FL_PICK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.capture   = req_valid;
         end
         ST_DECODE: begin
            cmd.wr_slot   = sts.trk && (sts.kind == EV_DOWN);
            cmd.scan_init = 1'b1;
         end
         ST_EMIT: begin
            cmd.out_single = sts.out_free;
         end
         ST_UP_SCAN: begin
            cmd.rd_en      = 1'b1;
            cmd.clear_slot = sts.up_hit;
         end
         ST_FL_PICK: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_flush = 1'b1;
         end
         ST_FL_EMIT: begin
            cmd.out_flush  = sts.out_free;
            cmd.clear_slot = sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/held_key_tracker_with_all_up_flush_core.sv
`default_nettype none

// Channel   Dir  Handshake       Payload
// req_ch    in   valid / ready   event_kind[1:0], key_value[7:0], time_ms[31:0]
// rsp_ch    out  valid / ready   is_release, keycode[7:0], stamp_ms[31:0], last
// csr       in   csr_we          csr_wdata (tracked_layout)
//
// One event at a time. Plain mode, key down, spare kind: capture, decode, emit.
// Key up scans the slot table one slot a cycle through the registered read
// port until a match or the last slot. All-keys-up picks and emits each key.
// Reset (synchronous) empties the table through the valid bits at once and
// sets tracked mode. A stalled rsp_ch holds the controller in its emit step.

module held_key_tracker_with_all_up_flush_core #(
   parameter int unsigned HELD_SLOTS = hktf_pkg::HELD_SLOTS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata,
   hktf_req_if.sink   req_ch,
   hktf_rsp_if.source rsp_ch
);
   import hktf_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   assign req_ch.ready = cmd.req_ready;

   // sequencer
   hktf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot table, event and result registers
   hktf_datapath #(
      .HELD_SLOTS (HELD_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_event_kind (req_ch.event_kind),
      .req_key_value  (req_ch.key_value),
      .req_time_ms    (req_ch.time_ms),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_is_release (rsp_ch.is_release),
      .rsp_keycode    (rsp_ch.keycode),
      .rsp_stamp_ms   (rsp_ch.stamp_ms),
      .rsp_last       (rsp_ch.last)
   );

endmodule

`default_nettype wire
